FILE: hdl/rlsg_pkg.sv
// ----------------------------------------------------------------------------
// rlsg_pkg
// Shared constants, codes and controller/datapath signal groups for the
// run-length smoothing and gap-fill block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlsg_pkg;

   // Field widths
   localparam int PIX_W     = 8;
   localparam int GAP_W     = 7;
   localparam int CSR_IDX_W = 1;

   // Default depth of the held-pixel buffer, and largest honoured gap
   localparam int MAX_GAP_DEFAULT = 64;

   // Gap register reset value and saturation of the distance counter
   localparam logic [GAP_W-1:0] GAP_RESET = 7'd35;
   localparam logic [GAP_W-1:0] DIST_SAT  = 7'd127;

   // Pixel value that marks foreground
   localparam logic [PIX_W-1:0] PIX_FG = '0;

   // Mode codes
   localparam logic MODE_SMOOTH = 1'b0;
   localparam logic MODE_FILL   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP  = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;       // take the input transaction
      logic load_direct;  // put the accepted pixel straight into the result register
      logic load_drain;   // put the next held pixel into the result register
      logic load_own;     // put the latched pixel of the item into the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic hold;          // the offered pixel is to be buffered, no result
      logic have_pending;  // the buffer holds pixels to be released
      logic out_free;      // the result register can take a value this cycle
      logic drain_done;    // the current held pixel is the last one
   } status_type;

endpackage

FILE: hdl/rlsg_if.sv
// ----------------------------------------------------------------------------
// rlsg_if
// Channel interfaces: pixel input, result output and register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rlsg_req_if;
   logic                      valid;
   logic                      ready;
   logic [rlsg_pkg::PIX_W-1:0] pixel;
   logic                      line_end;

   modport source (output valid, output pixel, output line_end, input ready);
   modport sink   (input valid, input pixel, input line_end, output ready);
endinterface

interface rlsg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rlsg_pkg::PIX_W-1:0] out_pixel;
   logic                      out_line_end;
   logic                      burst_last;

   modport source (output valid, output out_pixel, output out_line_end,
                   output burst_last, input ready);
   modport sink   (input valid, input out_pixel, input out_line_end,
                   input burst_last, output ready);
endinterface

interface rlsg_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rlsg_pkg::CSR_IDX_W-1:0] index;
   logic [rlsg_pkg::GAP_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rlsg_ctrl.sv
// ----------------------------------------------------------------------------
// rlsg_ctrl
// Controller: accepts pixels, sequences the release of held pixels and the
// item's own result into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlsg_pkg::status_type status,
   output rlsg_pkg::cmd_type    cmd
);
   import rlsg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_OWN   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!status.hold) begin
                  if (status.have_pending) begin
                     state_in = ST_DRAIN;
                  end else if (status.out_free) begin
                     cmd.load_direct = 1'b1;
                  end else begin
                     state_in = ST_OWN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.load_drain = 1'b1;
               if (status.drain_done) begin
                  state_in = ST_OWN;
               end
            end
         end
         ST_OWN: begin
            if (status.out_free) begin
               cmd.load_own = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/rlsg_datapath.sv
// ----------------------------------------------------------------------------
// rlsg_datapath
// Datapath: configuration and line state, held-pixel buffer memory, item
// latch and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlsg_datapath #(
   parameter int MAX_GAP = rlsg_pkg::MAX_GAP_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_wr,
   input  logic [rlsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlsg_pkg::GAP_W-1:0]     csr_data,
   // offered pixel
   input  logic [rlsg_pkg::PIX_W-1:0]     req_pixel,
   input  logic                           req_line_end,
   // result register
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [rlsg_pkg::PIX_W-1:0]     rsp_out_pixel,
   output logic                           rsp_out_line_end,
   output logic                           rsp_burst_last,
   // controller
   input  rlsg_pkg::cmd_type              cmd,
   output rlsg_pkg::status_type           status
);
   import rlsg_pkg::*;

   localparam int CNT_W = $clog2(MAX_GAP + 1);
   localparam int IDX_W = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;

   // Configuration
   logic             mode_ff;
   logic [GAP_W-1:0] gap_ff;

   // Line state
   logic             seen_ff, seen_in;
   logic [GAP_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   // Held-pixel buffer
   logic [PIX_W-1:0] pend_mem_ff [MAX_GAP];
   logic [PIX_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Latched item
   logic [CNT_W-1:0] drain_len_ff;
   logic             fill_ff;
   logic [PIX_W-1:0] own_val_ff;
   logic             own_last_ff;

   // Result register
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_pixel_ff;
   logic             out_line_end_ff;
   logic             out_burst_last_ff;

   // Decision logic for the offered pixel
   logic             is_fg;
   logic [GAP_W-1:0] gap_eff;
   logic [GAP_W-1:0] dist_inc;
   logic             hold;
   logic             fill;
   logic [PIX_W-1:0] own_val;

   always_comb begin
      is_fg    = (req_pixel == PIX_FG);
      gap_eff  = (gap_ff > GAP_W'(MAX_GAP)) ? GAP_W'(MAX_GAP) : gap_ff;
      dist_inc = (dist_ff == DIST_SAT) ? dist_ff : dist_ff + GAP_W'(1);
      hold     = (mode_ff == MODE_FILL) && !is_fg && seen_ff && (dist_inc < gap_eff)
                 && !req_line_end && (pend_cnt_ff < CNT_W'(MAX_GAP));
      fill     = is_fg && (dist_ff < gap_eff);
      if (is_fg) begin
         own_val = PIX_FG;
      end else if ((mode_ff == MODE_SMOOTH) && seen_ff && (dist_inc <= gap_eff)) begin
         own_val = PIX_FG;
      end else begin
         own_val = req_pixel;
      end
   end

   // Next line state
   always_comb begin
      seen_in     = seen_ff;
      dist_in     = dist_ff;
      pend_cnt_in = pend_cnt_ff;
      if (cmd.accept) begin
         if (is_fg) begin
            seen_in = 1'b1;
            dist_in = '0;
         end else if (seen_ff) begin
            dist_in = dist_inc;
         end
         pend_cnt_in = hold ? pend_cnt_ff + CNT_W'(1) : '0;
         if (req_line_end) begin
            seen_in = 1'b0;
            dist_in = '0;
         end
      end
   end

   // Status towards the controller
   always_comb begin
      status.hold         = hold;
      status.have_pending = (pend_cnt_ff != '0);
      status.out_free     = !out_valid_ff || rsp_ready;
      status.drain_done   = ((CNT_W'(idx_ff) + CNT_W'(1)) == drain_len_ff);
   end

   // Read address: restart at the head on accept, step on each release
   always_comb begin
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.load_drain) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // Configuration registers and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SMOOTH;
         gap_ff      <= GAP_RESET;
         seen_ff     <= 1'b0;
         dist_ff     <= '0;
         pend_cnt_ff <= '0;
         idx_ff      <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               CSR_MODE: mode_ff <= csr_data[0];
               CSR_GAP:  gap_ff  <= csr_data;
               default:  mode_ff <= mode_ff;
            endcase
         end
         seen_ff     <= seen_in;
         dist_ff     <= dist_in;
         pend_cnt_ff <= pend_cnt_in;
         idx_ff      <= idx_in;
      end
   end

   // Buffer memory: write when a pixel is held, registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && hold) begin
         pend_mem_ff[pend_cnt_ff[IDX_W-1:0]] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= pend_mem_ff[idx_in];
   end

   // Latch the item that releases results
   always_ff @(posedge clock) begin
      if (cmd.accept && !hold) begin
         drain_len_ff <= pend_cnt_ff;
         fill_ff      <= fill;
         own_val_ff   <= own_val;
         own_last_ff  <= req_line_end;
      end
   end

   // Result register
   always_comb begin
      if (cmd.load_direct || cmd.load_drain || cmd.load_own) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.load_direct) begin
         out_pixel_ff      <= own_val;
         out_line_end_ff   <= req_line_end;
         out_burst_last_ff <= 1'b1;
      end else if (cmd.load_drain) begin
         out_pixel_ff      <= fill_ff ? PIX_FG : rd_data_ff;
         out_line_end_ff   <= 1'b0;
         out_burst_last_ff <= 1'b0;
      end else if (cmd.load_own) begin
         out_pixel_ff      <= own_val_ff;
         out_line_end_ff   <= own_last_ff;
         out_burst_last_ff <= 1'b1;
      end else begin
         out_pixel_ff      <= out_pixel_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_pixel    = out_pixel_ff;
   assign rsp_out_line_end = out_line_end_ff;
   assign rsp_burst_last   = out_burst_last_ff;

endmodule

FILE: hdl/run_length_smoothing_gap_fill.sv
// ----------------------------------------------------------------------------
// run_length_smoothing_gap_fill
// Run-length smoothing and gap filling of binary scan lines. Pixels enter in
// scan order with line_end on the last pixel of a row (or column); 0 is
// foreground. Mode 0 zeroes background pixels up to gap positions after the
// latest foreground pixel of the line and gives one result per pixel. Mode 1
// holds background runs that follow foreground in a MAX_GAP-entry buffer
// memory and releases them as zeros when foreground closes them within gap,
// unchanged otherwise, so results come in bursts; burst_last marks the last
// result of each pixel. A held pixel, or one that gives its one result while
// nothing is held and the result register is free, leaves the block idle.
// A pixel that releases k held pixels first gives them out: the buffer memory
// has one registered read port and gives one held pixel per cycle while the
// result register is free, then the pixel's own result follows.
// Write the mode and gap registers only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_length_smoothing_gap_fill #(
   parameter int MAX_GAP = rlsg_pkg::MAX_GAP_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rlsg_req_if.sink   req_ch,
   rlsg_rsp_if.source rsp_ch,
   rlsg_csr_if.sink   csr_ch
);
   import rlsg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers are always writable
   assign csr_ch.ready = 1'b1;

   rlsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rlsg_datapath #(
      .MAX_GAP (MAX_GAP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .req_pixel        (req_ch.pixel),
      .req_line_end     (req_ch.line_end),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_out_pixel    (rsp_ch.out_pixel),
      .rsp_out_line_end (rsp_ch.out_line_end),
      .rsp_burst_last   (rsp_ch.burst_last),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef SYNTHESIS
   // The final result of a line always closes a burst
   a_line_end_closes_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_line_end |-> rsp_ch.burst_last)
      else $error("line end result without burst_last");

   // At most one source loads the result register
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_direct, cmd.load_drain, cmd.load_own}))
      else $error("result register loaded from two sources");

   // A pixel at the end of a line is never held
   a_no_hold_at_line_end: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.hold |-> !req_ch.line_end)
      else $error("pixel held at line end");

   // A released held pixel never closes a burst
   a_drain_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_drain |=> rsp_ch.valid && !rsp_ch.burst_last)
      else $error("released pixel marked as burst end");
`endif

endmodule
